// ===== sv/ndd_pkg.sv =====
package ndd_pkg;

  // Build-time sizes
  localparam int NUM_SPECIES  = 8;
  localparam int NUM_HABITATS = 4;
  localparam int COUNT_BITS   = 4;

  // Field widths
  localparam int PROB_W     = 16;
  localparam int SPEC_W     = 4;
  localparam int HAB_W      = 2;
  localparam int TIDX_W     = 8;
  localparam int CNT_PACK_W = 32;
  localparam int RND_W      = 32;

  // Derived sizes
  localparam int TABLE_DEPTH = NUM_HABITATS * NUM_SPECIES * NUM_SPECIES;
  localparam int TADDR_W     = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(NUM_SPECIES);
  localparam int PACK_W      = NUM_SPECIES * COUNT_BITS;
  localparam int W_W         = PROB_W + COUNT_BITS;
  localparam int WSUM_W      = W_W + IDX_W;
  localparam int SURV_W      = RND_W + 1;
  localparam int Q_W         = PROB_W + 1;
  localparam int PROD_W      = SURV_W + WSUM_W;
  localparam int ACALC_W     = HAB_W + 2 * SPEC_W + 2;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPETE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [TIDX_W-1:0]     table_index;
    logic [PROB_W-1:0]     prob_value;
    logic [SPEC_W-1:0]     cell_species;
    logic [HAB_W-1:0]      habitat;
    logic [CNT_PACK_W-1:0] neighbor_counts;
    logic [RND_W-1:0]      random_value;
  } item_t;

  typedef struct packed {
    logic [SPEC_W-1:0] winner;
    logic              displaced;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_RD,
    ST_LOAD,
    ST_SMUL,
    ST_SUPD,
    ST_SUMCHK,
    ST_DSET,
    ST_WACC,
    ST_WMUL,
    ST_WCMP,
    ST_FIN
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic tbl_wr;
    logic start;
    logic load;
    logic next_sp;
    logic smul;
    logic supd;
    logic dmul;
    logic dset;
    logic wacc;
    logic wmul;
    logic set_keep;
    logic set_win;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cell_bad;
    logic last_sp;
    logic cnt_zero;
    logic cnt_last;
    logic keep;
    logic hit;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== sv/ndd_if.sv =====
interface ndd_item_if import ndd_pkg::*;;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ndd_result_if import ndd_pkg::*;;
  logic    valid;
  logic    ready;
  result_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== sv/ndd_ram.sv =====
module ndd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ndd_ctrl.sv =====
module ndd_ctrl import ndd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  op_t      in_op,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_COMPETE) begin
            cmd.start  = 1'b1;
            state_next = ST_CHK;
          end else begin
            cmd.tbl_wr = 1'b1;
          end
        end
      end
      ST_CHK: begin
        if (sts.cell_bad) begin
          cmd.set_keep = 1'b1;
          state_next   = ST_FIN;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD: state_next = ST_LOAD;
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (!sts.cnt_zero) begin
          state_next = ST_SMUL;
        end else if (sts.last_sp) begin
          state_next = ST_SUMCHK;
        end else begin
          cmd.next_sp = 1'b1;
          state_next  = ST_RD;
        end
      end
      ST_SMUL: begin
        cmd.smul   = 1'b1;
        state_next = ST_SUPD;
      end
      ST_SUPD: begin
        cmd.supd = 1'b1;
        if (!sts.cnt_last) begin
          state_next = ST_SMUL;
        end else if (sts.last_sp) begin
          state_next = ST_SUMCHK;
        end else begin
          cmd.next_sp = 1'b1;
          state_next  = ST_RD;
        end
      end
      ST_SUMCHK: begin
        if (sts.keep) begin
          cmd.set_keep = 1'b1;
          state_next   = ST_FIN;
        end else begin
          cmd.dmul   = 1'b1;
          state_next = ST_DSET;
        end
      end
      ST_DSET: begin
        cmd.dset   = 1'b1;
        state_next = ST_WACC;
      end
      ST_WACC: begin
        cmd.wacc   = 1'b1;
        state_next = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.wmul   = 1'b1;
        state_next = ST_WCMP;
      end
      ST_WCMP: begin
        if (sts.hit) begin
          cmd.set_win = 1'b1;
          state_next  = ST_FIN;
        end else if (sts.last_sp) begin
          state_next = ST_FIN;
        end else begin
          cmd.next_sp = 1'b1;
          state_next  = ST_WACC;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/ndd_dp.sv =====
module ndd_dp import ndd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  item_t              in_item,
  input  logic               cfg_wr_en,
  input  logic [SPEC_W-1:0]  cfg_wr_data,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  ndd_result_if.source       result_ch
);

  localparam logic [SURV_W-1:0] ONE_Q = {1'b1, {RND_W{1'b0}}};

  logic [SPEC_W-1:0]     spc_cfg;
  logic [SPEC_W-1:0]     spc;
  logic [SPEC_W-1:0]     res_sp;
  logic [HAB_W-1:0]      hab;
  logic [CNT_PACK_W-1:0] counts;
  logic [RND_W-1:0]      rnd;
  logic [ACALC_W-1:0]    base;
  logic [IDX_W-1:0]      idx;
  logic [PROB_W-1:0]     p;
  logic [COUNT_BITS-1:0] cnt;
  logic [SURV_W-1:0]     surv;
  logic [W_W-1:0]        w [NUM_SPECIES];
  logic [WSUM_W-1:0]     wsum;
  logic [WSUM_W-1:0]     run;
  logic [PROD_W-1:0]     target;
  logic [PROD_W-1:0]     prod;
  logic                  rd_ok;
  logic [SPEC_W-1:0]     winner;
  logic                  displaced;
  logic                  out_valid;
  result_t               out_item;

  logic [ACALC_W-1:0]           addr_calc;
  logic [PROB_W-1:0]            rdata;
  logic [PACK_W+CNT_PACK_W-1:0] counts_ext;
  logic [COUNT_BITS-1:0]        cur_c;
  logic [W_W-1:0]               w_new;
  logic [SURV_W-1:0]            mul_a;
  logic [WSUM_W-1:0]            mul_b;
  logic [Q_W-1:0]               q;
  logic                         tbl_we;

  // Species in use, limited to 1..NUM_SPECIES
  always_comb begin
    if (spc_cfg == '0) begin
      spc = SPEC_W'(1);
    end else if (spc_cfg > SPEC_W'(NUM_SPECIES)) begin
      spc = SPEC_W'(NUM_SPECIES);
    end else begin
      spc = spc_cfg;
    end
  end

  // Table address and per-species count
  assign addr_calc  = base + ACALC_W'(idx) * ACALC_W'(spc) + ACALC_W'(res_sp) - ACALC_W'(1);
  assign counts_ext = {{PACK_W{1'b0}}, counts};
  assign cur_c      = counts_ext[idx*COUNT_BITS +: COUNT_BITS];
  assign w_new      = W_W'(rd_ok ? rdata : '0) * W_W'(cur_c);
  assign q          = Q_W'(1 << PROB_W) - Q_W'(p);
  assign tbl_we     = cmd.tbl_wr && (ACALC_W'(in_item.table_index) < ACALC_W'(TABLE_DEPTH));

  ndd_ram #(
    .WIDTH (PROB_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TADDR_W'(in_item.table_index)),
    .wdata (in_item.prob_value),
    .raddr (addr_calc[TADDR_W-1:0]),
    .rdata (rdata)
  );

  // Shared multiplier operand select
  always_comb begin
    if (cmd.smul) begin
      mul_a = surv;
      mul_b = WSUM_W'(q);
    end else if (cmd.dmul) begin
      mul_a = SURV_W'(rnd) - surv;
      mul_b = wsum;
    end else begin
      mul_a = ONE_Q - surv;
      mul_b = run;
    end
  end

  // Status
  always_comb begin
    sts.cell_bad = (res_sp == '0) || (res_sp > spc);
    sts.last_sp  = (SPEC_W'(idx) + SPEC_W'(1)) == spc;
    sts.cnt_zero = (cur_c == '0);
    sts.cnt_last = (cnt == COUNT_BITS'(1));
    sts.keep     = (wsum == '0) || (SURV_W'(rnd) <= surv);
    sts.hit      = (target <= prod);
    sts.out_free = !out_valid || result_ch.ready;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      spc_cfg <= SPEC_W'(NUM_SPECIES);
    end else if (cfg_wr_en) begin
      spc_cfg <= cfg_wr_data;
    end
  end

  // Item registers and loop state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_sp <= in_item.cell_species;
      hab    <= in_item.habitat;
      counts <= in_item.neighbor_counts;
      rnd    <= in_item.random_value;
      base   <= ACALC_W'(in_item.habitat) * ACALC_W'(spc) * ACALC_W'(spc);
      surv   <= ONE_Q;
      wsum   <= '0;
      idx    <= '0;
    end
    rd_ok <= (ACALC_W'(hab) < ACALC_W'(NUM_HABITATS)) &&
             (addr_calc < ACALC_W'(TABLE_DEPTH));
    if (cmd.load) begin
      p      <= rd_ok ? rdata : '0;
      cnt    <= cur_c;
      w[idx] <= w_new;
      wsum   <= wsum + WSUM_W'(w_new);
    end
    if (cmd.next_sp) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.smul || cmd.dmul || cmd.wmul) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.supd) begin
      surv <= prod[PROB_W +: SURV_W];
      cnt  <= cnt - COUNT_BITS'(1);
    end
    if (cmd.dset) begin
      target    <= prod;
      run       <= '0;
      idx       <= '0;
      winner    <= spc;
      displaced <= 1'b1;
    end
    if (cmd.wacc) begin
      run <= run + WSUM_W'(w[idx]);
    end
    if (cmd.set_keep) begin
      winner    <= res_sp;
      displaced <= 1'b0;
    end
    if (cmd.set_win) begin
      winner    <= SPEC_W'(idx) + SPEC_W'(1);
      displaced <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.winner    <= winner;
      out_item.displaced <= displaced;
    end
  end

  assign result_ch.valid = out_valid;
  assign result_ch.item  = out_item;

`ifndef NO_ASSERTIONS
  // survival mass never grows past one
  a_surv_le_one: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.supd) |-> surv <= ONE_Q)
    else $error("survival above one");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || result_ch.ready))
    else $error("result overwritten");

  // the walk only runs with a nonzero weight sum
  a_walk_wsum: assert property (@(posedge clk) disable iff (rst)
    cmd.wmul |-> wsum != '0)
    else $error("walk with zero weights");

  // a displacing winner is a species in use
  a_winner_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.displaced) |-> (out_item.winner != '0 && out_item.winner <= spc))
    else $error("winner out of range");
`endif

endmodule

// ===== sv/neighbor_displacement_draw_core.sv =====
// A write beat is taken in the idle state; a competition reads and loads each species in use,
//   steps the shared multiplier once per neighbor count unit, then walks the species for the winner.
// Throughput: one item at a time; an invalid resident skips the table and goes straight to the result.
// The finished result sits in an output register, so the next item can be taken.
// Reset (rst, synchronous) clears control and sets species_in_use to NUM_SPECIES;
//   the probability table is not cleared and must be written before use.
module neighbor_displacement_draw_core import ndd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ndd_item_if.sink          item_ch,
  ndd_result_if.source      result_ch,
  input  logic              cfg_wr_en,
  input  logic [SPEC_W-1:0] cfg_wr_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ndd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_ch.valid),
    .in_op    (item_ch.item.operation),
    .in_ready (item_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ndd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_item     (item_ch.item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .result_ch   (result_ch)
  );

endmodule

// ===== bench/neighbor_displacement_draw_core_tb.sv =====
`timescale 1ns / 1ps

module neighbor_displacement_draw_core_tb;
  import ndd_pkg::*;

  localparam int DRAIN_CYCLES = 400;  // longer than the slowest competition

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [SPEC_W-1:0] cfg_wr_data;

  ndd_item_if   item_ch ();
  ndd_result_if result_ch ();

  neighbor_displacement_draw_core uut (
    .clk        (clk),
    .rst        (rst),
    .item_ch    (item_ch.sink),
    .result_ch  (result_ch.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Mirror of the block state
  logic [PROB_W-1:0] prob_mirror [TABLE_DEPTH];
  logic [SPEC_W-1:0] species_setting;
  result_t           draw_expect [$];
  int                error_count;
  bit                stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Expected outcome of one competition beat
  function automatic result_t predict_draw(item_t it);
    int unsigned       s, c, i, k;
    longint unsigned   surv, wsum, run, rest, bound, p;
    longint unsigned   w [NUM_SPECIES];
    result_t           res;
    s = species_setting;
    if (s < 1) s = 1;
    if (s > NUM_SPECIES) s = NUM_SPECIES;
    res.winner = it.cell_species;
    res.displaced = 1'b0;
    if (it.cell_species < 1 || it.cell_species > s) return res;
    surv = 64'h1_0000_0000;
    wsum = 0;
    for (i = 0; i < s; i++) begin
      if (it.habitat >= NUM_HABITATS) p = 0;
      else p = prob_mirror[it.habitat * s * s + i * s + it.cell_species - 1];
      c = (i * COUNT_BITS >= CNT_PACK_W) ? 0 : (it.neighbor_counts >> (i * COUNT_BITS)) & 4'hF;
      for (k = 0; k < c; k++) surv = (surv * (65536 - p)) >> 16;
      w[i] = p * c;
      wsum += w[i];
    end
    if (wsum == 0 || it.random_value <= surv) return res;
    rest = 64'h1_0000_0000 - surv;
    res.winner = SPEC_W'(s);
    res.displaced = 1'b1;
    run = 0;
    for (i = 0; i < s; i++) begin
      run += w[i];
      bound = surv + (run * rest) / wsum;
      if (it.random_value <= bound) begin
        res.winner = SPEC_W'(i + 1);
        break;
      end
    end
    return res;
  endfunction

  // Send one beat; valid stays high until the next call decides otherwise
  task automatic send_beat(item_t it);
    @(negedge clk);
    while (stall_on && $urandom_range(99) < 21) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.item  <= it;
    do @(posedge clk); while (!item_ch.ready);
    if (it.operation == OP_WRITE) prob_mirror[it.table_index] = it.prob_value;
    else draw_expect.push_back(predict_draw(it));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (draw_expect.size() != 0) @(posedge clk);
  endtask

  // Register write only with the block idle
  task automatic set_species(int unsigned n);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[SPEC_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    species_setting = n[SPEC_W-1:0];
  endtask

  function automatic item_t write_beat(int unsigned idx, int unsigned val);
    item_t it;
    it = '0;
    it.operation   = OP_WRITE;
    it.table_index = idx[TIDX_W-1:0];
    it.prob_value  = val[PROB_W-1:0];
    it.cell_species = SPEC_W'($urandom());
    it.habitat      = HAB_W'($urandom());
    it.neighbor_counts = $urandom();
    it.random_value    = $urandom();
    return it;
  endfunction

  function automatic item_t draw_beat(int unsigned res_sp, int unsigned hab,
                                      logic [31:0] counts, logic [31:0] rnd);
    item_t it;
    it.operation       = OP_COMPETE;
    it.table_index     = TIDX_W'($urandom());
    it.prob_value      = PROB_W'($urandom());
    it.cell_species    = res_sp[SPEC_W-1:0];
    it.habitat         = hab[HAB_W-1:0];
    it.neighbor_counts = counts;
    it.random_value    = rnd;
    return it;
  endfunction

  function automatic item_t random_draw();
    int unsigned s, res_sp, sel;
    logic [31:0] counts;
    s = (species_setting < 1) ? 1 : (species_setting > NUM_SPECIES) ? NUM_SPECIES
                                                                   : species_setting;
    res_sp = ($urandom_range(99) < 88) ? $urandom_range(s, 1) : $urandom_range(15);
    sel = $urandom_range(9);
    if (sel < 5) begin
      counts = '0;
      for (int i = 0; i < NUM_SPECIES; i++) counts[i*4 +: 4] = 4'($urandom_range(3));
    end else if (sel < 8) begin
      counts = $urandom();
    end else begin
      counts = '0;
      counts[$urandom_range(7)*4 +: 4] = 4'($urandom());
    end
    return draw_beat(res_sp, $urandom_range(3), counts,
                     ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom());
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (draw_expect.size() == 0) begin
        $display("%0t: unexpected result beat winner=%0d displaced=%0b", $time,
                 result_ch.item.winner, result_ch.item.displaced);
        error_count++;
      end else begin
        want = draw_expect.pop_front();
        if (result_ch.item.winner !== want.winner) begin
          $display("%0t: winner expected %0d actual %0d", $time, want.winner,
                   result_ch.item.winner);
          error_count++;
        end
        if (result_ch.item.displaced !== want.displaced) begin
          $display("%0t: displaced expected %0b actual %0b", $time, want.displaced,
                   result_ch.item.displaced);
          error_count++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    result_ch.ready <= !(stall_on && $urandom_range(99) < 21);
  end

  // Every entry written first, so no read hits an unwritten entry
  task automatic test_table_fill();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i % 17)
        0: send_beat(write_beat(i, 0));
        1: send_beat(write_beat(i, 16'hFFFF));
        default: send_beat(write_beat(i, $urandom()));
      endcase
    end
  endtask

  task automatic test_directed();
    set_species(NUM_SPECIES);
    // no neighbors at all: zero weights
    send_beat(draw_beat(3, 0, 32'h0, 32'hFFFF_FFFF));
    // invalid residents
    send_beat(draw_beat(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(draw_beat(9, 2, 32'h1111_1111, 32'h8000_0000));
    send_beat(draw_beat(15, 3, 32'h1111_1111, 32'h0));
    // full counts, both random extremes
    send_beat(draw_beat(1, 3, 32'hFFFF_FFFF, 32'h0));
    send_beat(draw_beat(8, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // habitat 2 all-zero probabilities for resident 2: zero weights
    for (int i = 0; i < NUM_SPECIES; i++) send_beat(write_beat(2*64 + i*8 + 1, 0));
    send_beat(draw_beat(2, 2, 32'h5555_5555, 32'hFFFF_FFFF));
    // same species strongly displaces itself
    for (int i = 0; i < NUM_SPECIES; i++)
      send_beat(write_beat(1*64 + i*8 + 4, (i == 4) ? 16'hFFFF : 0));
    send_beat(draw_beat(5, 1, 32'h000F_0000, 32'hFFFF_FFFF));
    send_beat(draw_beat(5, 1, 32'h0001_0000, 32'h0000_0001));
    // smallest setting: only species 1 takes part
    set_species(1);
    send_beat(draw_beat(1, 0, 32'h0000_000F, 32'hFFFF_FFFF));
    send_beat(draw_beat(2, 0, 32'h0000_000F, 32'hFFFF_FFFF));
  endtask

  // Sender waits for each result before the next beat
  task automatic test_paced_draws();
    set_species(6);
    for (int n = 0; n < 20; n++) begin
      send_beat(random_draw());
      wait_drain();
    end
  endtask

  task automatic test_random_phases();
    int unsigned settings [7] = '{8, 15, 0, 3, 5, 2, 7};
    for (int ph = 0; ph < 7; ph++) begin
      set_species(settings[ph]);
      stall_on = (ph != 0);
      for (int n = 0; n < 75; n++) begin
        if ($urandom_range(99) < 10) send_beat(write_beat($urandom(), $urandom()));
        else send_beat(random_draw());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    item_ch.valid = 1'b0;
    item_ch.item = '0;
    result_ch.ready = 1'b0;
    species_setting = NUM_SPECIES;
    error_count = 0;
    stall_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_directed();
    test_paced_draws();
    test_random_phases();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && draw_expect.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
